/* src/rfhr_pkg.sv */
package rfhr_pkg;

   // Parser phases; code 7 is unused and handled as the hunt
   typedef enum logic [2:0] {
      PH_HUNT_A  = 3'd0,
      PH_SYNC_D  = 3'd1,
      PH_SYNC_A  = 3'd2,
      PH_CNT_HI  = 3'd3,
      PH_CNT_LO  = 3'd4,
      PH_CHECK   = 3'd5,
      PH_DATA    = 3'd6
   } phase_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_HEADER    = 2'd0,
      KIND_DATA      = 2'd1,
      KIND_HANDSHAKE = 2'd2
   } kind_type;

   // Input command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam int LEN_W = 18;
   localparam int IDLE_W = 16;

   localparam logic [7:0] SYNC_A_UPPER = 8'h41;   // 'A'
   localparam logic [7:0] SYNC_D       = 8'h64;   // 'd'
   localparam logic [7:0] SYNC_A_LOWER = 8'h61;   // 'a'
   localparam logic [7:0] CHECK_XOR    = 8'h55;

   localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RESET = 16'd15000;
   localparam logic [IDLE_W-1:0] IDLE_MAX           = 16'hFFFF;
   localparam logic [LEN_W-1:0]  FRAME_TOTAL_RESET  = 18'd3;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data_byte;
      logic [LEN_W-1:0] data_index;
      logic [LEN_W-1:0] frame_length;
      logic             last;
   } result_type;

endpackage

/* src/rfhr_parser.sv */
module rfhr_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      cmd,
   input  logic [7:0]                rx_byte,
   input  logic [15:0]               idle_timeout,
   output logic                      res_valid,
   output rfhr_pkg::result_type      res
);
   import rfhr_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [7:0]        count_high_ff, count_high_in;
   logic [7:0]        count_low_ff, count_low_in;
   logic [LEN_W-1:0]  byte_position_ff, byte_position_in;
   logic [LEN_W-1:0]  frame_total_ff, frame_total_in;
   logic [IDLE_W-1:0] idle_count_ff, idle_count_in;

   logic [IDLE_W-1:0] idle_bump;
   logic [16:0]       group_count;
   logic [LEN_W-1:0]  new_total;
   logic [LEN_W-1:0]  next_pos;
   logic              fin;

   // saturating idle count and frame length 3 * (count + 1)
   assign idle_bump = (idle_count_ff < IDLE_MAX) ? idle_count_ff + 16'd1 : idle_count_ff;
   assign group_count = {1'b0, count_high_ff, count_low_ff} + 17'd1;
   assign new_total = {group_count, 1'b0} + {1'b0, group_count};
   assign next_pos  = byte_position_ff + 18'd1;
   assign fin       = (next_pos == frame_total_ff);

   // next state and result for one word
   always_comb begin
      phase_in         = phase_ff;
      count_high_in    = count_high_ff;
      count_low_in     = count_low_ff;
      byte_position_in = byte_position_ff;
      frame_total_in   = frame_total_ff;
      idle_count_in    = idle_count_ff;
      res_valid        = 1'b0;
      res              = '0;
      if (cmd == CMD_TICK) begin
         idle_count_in = idle_bump;
         if (idle_bump > idle_timeout) begin
            phase_in      = PH_HUNT_A;
            idle_count_in = '0;
            res_valid     = 1'b1;
            res.kind      = KIND_HANDSHAKE;
         end
      end else begin
         idle_count_in = '0;
         unique case (phase_ff)
            PH_SYNC_D: begin
               phase_in = (rx_byte == SYNC_D) ? PH_SYNC_A : PH_HUNT_A;
            end
            PH_SYNC_A: begin
               phase_in = (rx_byte == SYNC_A_LOWER) ? PH_CNT_HI : PH_HUNT_A;
            end
            PH_CNT_HI: begin
               count_high_in = rx_byte;
               phase_in      = PH_CNT_LO;
            end
            PH_CNT_LO: begin
               count_low_in = rx_byte;
               phase_in     = PH_CHECK;
            end
            PH_CHECK: begin
               if (rx_byte == (count_high_ff ^ count_low_ff ^ CHECK_XOR)) begin
                  frame_total_in   = new_total;
                  byte_position_in = '0;
                  phase_in         = PH_DATA;
                  res_valid        = 1'b1;
                  res.kind         = KIND_HEADER;
                  res.frame_length = new_total;
               end else begin
                  phase_in = PH_HUNT_A;
               end
            end
            PH_DATA: begin
               res_valid        = 1'b1;
               res.kind         = KIND_DATA;
               res.data_byte    = rx_byte;
               res.data_index   = byte_position_ff;
               res.frame_length = frame_total_ff;
               res.last         = fin;
               byte_position_in = next_pos;
               if (fin) begin
                  phase_in = PH_HUNT_A;
               end
            end
            default: begin
               phase_in = (rx_byte == SYNC_A_UPPER) ? PH_SYNC_D : PH_HUNT_A;
            end
         endcase
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT_A;
         count_high_ff    <= '0;
         count_low_ff     <= '0;
         byte_position_ff <= '0;
         frame_total_ff   <= FRAME_TOTAL_RESET;
         idle_count_ff    <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         count_high_ff    <= count_high_in;
         count_low_ff     <= count_low_in;
         byte_position_ff <= byte_position_in;
         frame_total_ff   <= frame_total_in;
         idle_count_ff    <= idle_count_in;
      end
   end

endmodule

/* src/rfhr_out_reg.sv */
module rfhr_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  rfhr_pkg::result_type   res_in,
   input  logic                   out_ready,
   output logic                   out_valid,
   output rfhr_pkg::result_type   res_out
);
   import rfhr_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff;

   // a new result replaces one taken in the same cycle
   assign valid_in = load | (valid_ff & ~out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = valid_ff;
   assign res_out   = res_ff;

endmodule

/* src/rgb_frame_header_receiver.sv */
// An accepted input word is held in the input register, and its result word in the result register.
// Throughput: one input word per cycle; the input register feeds the parser
// whenever the result register is empty or being drained in that cycle.
// Reset (synchronous, active high) returns the parser to the sync hunt, clears
// the idle count and both stage valids, and sets the idle timeout to 15000 ms.
module rgb_frame_header_receiver (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // [7:0] rx_byte
   input  logic         req_tuser,    // [0] cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,    // [7:0] data_byte, [25:8] data_index,
                                      // [43:26] frame_length, [47:44] zero
   output logic [1:0]   rsp_tuser,    // [1:0] kind
   output logic         rsp_tlast,    // last
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data      // idle_timeout_ms
);
   import rfhr_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic              in_cmd_ff;
   logic [7:0]        in_byte_ff;
   logic [IDLE_W-1:0] timeout_ff;
   logic              step;
   logic              res_valid;
   result_type        res;
   result_type        out_res;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= IDLE_TIMEOUT_RESET;
      end else if (csr_valid) begin
         timeout_ff <= csr_data;
      end
   end

   // input register; a held word moves on when the result side has room
   assign step        = in_valid_ff & (~rsp_tvalid | rsp_tready);
   assign req_tready  = ~in_valid_ff | step;
   assign in_valid_in = (req_tvalid & req_tready) | (in_valid_ff & ~step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   rfhr_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .cmd          (in_cmd_ff),
      .rx_byte      (in_byte_ff),
      .idle_timeout (timeout_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   rfhr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step & res_valid),
      .res_in    (res),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .res_out   (out_res)
   );

   // pack the result word
   assign rsp_tdata = {4'b0000, out_res.frame_length, out_res.data_index, out_res.data_byte};
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.last;

endmodule
